// ===== sv/array_double_ended_queue_assert.svh =====
// assertion macros for the deque checker
`ifndef ARRAY_DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define ARRAY_DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ADE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ADE_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ade_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ade_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int CAP_W          = 5;
  localparam int PORT_W         = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] FUNC_PUSH_FRONT = 2'd0;
  localparam logic [1:0] FUNC_PUSH_REAR  = 2'd1;
  localparam logic [1:0] FUNC_POP_FRONT  = 2'd2;
  localparam logic [1:0] FUNC_POP_REAR   = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL_REAR = 2'd1;
  localparam logic [1:0] ST_NO_FRONT  = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  // classified operation
  typedef struct packed {
    logic is_push;
    logic at_front;
  } op_t;

  // command queue status
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

// ===== sv/ade_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ade_front #(
  parameter int DATA_WIDTH = ade_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        take,
  input  wire logic [1:0]                  func,
  input  wire logic signed [ade_pkg::PORT_W-1:0] push_value,
  input  wire logic                        q_full,
  output logic                             q_wr,
  output ade_pkg::op_t                     q_op,
  output logic [DATA_WIDTH-1:0]            q_data,
  output logic                             holding
);

  logic                  valid;
  ade_pkg::op_t          op;
  logic [DATA_WIDTH-1:0] data;
  ade_pkg::op_t          op_dec;

  always_comb begin
    op_dec.is_push  = (func == ade_pkg::FUNC_PUSH_FRONT) || (func == ade_pkg::FUNC_PUSH_REAR);
    op_dec.at_front = (func == ade_pkg::FUNC_PUSH_FRONT) || (func == ade_pkg::FUNC_POP_FRONT);
  end

  assign q_wr    = valid && !q_full;
  assign q_op    = op;
  assign q_data  = data;
  assign holding = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take && (!valid || q_wr)) begin
      valid <= 1'b1;
    end else if (q_wr) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && (!valid || q_wr)) begin
      op   <= op_dec;
      data <= DATA_WIDTH'($unsigned(push_value));
    end
  end

endmodule

`default_nettype wire

// ===== sv/ade_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ade_cmd_queue #(
  parameter int W = 34
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd,
  output logic [W-1:0]      rd_data,
  output ade_pkg::q_stat_t  stat
);

  logic [W-1:0] slots [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_wr;
  logic         do_rd;

  assign do_wr      = wr && (count != 2'd2);
  assign do_rd      = rd && (count != 2'd0);
  assign rd_data    = slots[rd_ptr];
  assign stat.empty = (count == 2'd0);
  assign stat.full  = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) slots[wr_ptr] <= wr_data;
  end

endmodule

`default_nettype wire

// ===== sv/ade_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ade_back #(
  parameter int DEPTH      = ade_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ade_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [ade_pkg::CAP_W-1:0]    capacity,
  input  wire logic                         q_empty,
  input  wire ade_pkg::op_t                 q_op,
  input  wire logic [DATA_WIDTH-1:0]        q_data,
  output logic                              q_rd,
  output logic                              done,
  output logic signed [ade_pkg::PORT_W-1:0] pop_value,
  output logic [1:0]                        status,
  output logic                              working
);

  localparam int PW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = (PW > ade_pkg::CAP_W) ? PW : ade_pkg::CAP_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;
  logic [PW-1:0]         front_pos, front_pos_next;
  logic [PW-1:0]         rear_pos, rear_pos_next;
  logic                  pending;
  logic                  pend_pop;
  logic [1:0]            pend_status;

  logic [CW-1:0]         cap_x, eff_cap;
  logic                  mem_we, mem_re, pop_ok;
  logic [AW-1:0]         addr;
  logic [1:0]            st;
  logic                  has_items;

  assign q_rd    = !pending && !q_empty;
  assign working = pending;

  always_comb begin
    cap_x = CW'(capacity);
    if (cap_x == '0) eff_cap = CW'(1);
    else if (cap_x > CW'(DEPTH)) eff_cap = CW'(DEPTH);
    else eff_cap = cap_x;
  end

  assign has_items = front_pos < rear_pos;

  always_comb begin
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    pop_ok         = 1'b0;
    addr           = '0;
    st             = ade_pkg::ST_OK;
    front_pos_next = front_pos;
    rear_pos_next  = rear_pos;
    if (q_op.is_push && q_op.at_front) begin
      if (front_pos != '0) begin
        mem_we         = 1'b1;
        addr           = AW'(front_pos - PW'(1));
        front_pos_next = front_pos - PW'(1);
      end else begin
        st = ade_pkg::ST_NO_FRONT;
      end
    end else if (q_op.is_push) begin
      if (CW'(rear_pos) < eff_cap) begin
        mem_we        = 1'b1;
        addr          = AW'(rear_pos);
        rear_pos_next = rear_pos + PW'(1);
      end else begin
        st = ade_pkg::ST_FULL_REAR;
      end
    end else if (!has_items) begin
      st = ade_pkg::ST_EMPTY;
    end else if (q_op.at_front) begin
      mem_re         = 1'b1;
      pop_ok         = 1'b1;
      addr           = AW'(front_pos);
      front_pos_next = front_pos + PW'(1);
    end else begin
      mem_re        = 1'b1;
      pop_ok        = 1'b1;
      addr          = AW'(rear_pos - PW'(1));
      rear_pos_next = rear_pos - PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= 1'b0;
      front_pos <= '0;
      rear_pos  <= '0;
    end else begin
      pending <= q_rd;
      if (q_rd) begin
        front_pos <= front_pos_next;
        rear_pos  <= rear_pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      pend_pop    <= pop_ok;
      pend_status <= st;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd && mem_we) mem[addr] <= q_data;
    if (q_rd && mem_re) rd_q <= mem[addr];
  end

  assign done      = pending;
  assign status    = pend_status;
  assign pop_value = pend_pop ? ade_pkg::PORT_W'(signed'(rd_q)) : '1;

endmodule

`default_nettype wire

// ===== sv/array_double_ended_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

// double-ended queue held in a linear array of DEPTH slots
// command channel: a transaction is taken at a rising edge with start high and
//   busy low; func picks push front, push rear, pop front or pop rear, and
//   push_value carries the data for pushes
// result channel: done is high for one cycle with pop_value and status;
//   the receiver cannot stall, so the result must be taken in that cycle
// latency: done rises in the third cycle after the accepting edge
// throughput: one transaction every four cycles; busy stays high from the
//   accept until done, set by the front register, the command queue and the
//   registered read of the slot memory
// config: cfg_we writes cfg_wdata into capacity (slots in use); capacity 0
//   acts as 1 and values above DEPTH act as DEPTH; write only while idle
// reset: both indices go to the empty position and capacity to 16; the slot
//   memory is not cleared, a pop only reads slots that a push wrote
// status: ok, full at rear, no room at front, empty; pop_value is all ones
//   for pushes and for pops on an empty queue
module array_double_ended_queue #(
  parameter int DEPTH      = ade_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = ade_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        func,
  input  wire logic signed [ade_pkg::PORT_W-1:0] push_value,
  output logic                                   done,
  output logic signed [ade_pkg::PORT_W-1:0]      pop_value,
  output logic [1:0]                             status,
  input  wire logic                              cfg_we,
  input  wire logic [ade_pkg::CAP_W-1:0]         cfg_wdata
);

  localparam int QW = $bits(ade_pkg::op_t) + DATA_WIDTH;

  // capacity register
  logic [ade_pkg::CAP_W-1:0] capacity;

  // front to queue
  logic                  f_wr;
  ade_pkg::op_t          f_op;
  logic [DATA_WIDTH-1:0] f_data;
  logic                  f_holding;

  // queue to back
  ade_pkg::q_stat_t      q_stat;
  logic [QW-1:0]         q_out;
  logic                  q_rd;
  logic                  b_working;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= ade_pkg::CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  // one transaction in flight anywhere keeps the block busy
  assign busy = f_holding || !q_stat.empty || b_working;

  ade_front #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (start && !busy),
    .func      (func),
    .push_value(push_value),
    .q_full    (q_stat.full),
    .q_wr      (f_wr),
    .q_op      (f_op),
    .q_data    (f_data),
    .holding   (f_holding)
  );

  // short command queue decouples classification from execution
  ade_cmd_queue #(
    .W(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_wr),
    .wr_data({f_op, f_data}),
    .rd     (q_rd),
    .rd_data(q_out),
    .stat   (q_stat)
  );

  ade_back #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .capacity (capacity),
    .q_empty  (q_stat.empty),
    .q_op     (ade_pkg::op_t'(q_out[QW-1:DATA_WIDTH])),
    .q_data   (q_out[DATA_WIDTH-1:0]),
    .q_rd     (q_rd),
    .done     (done),
    .pop_value(pop_value),
    .status   (status),
    .working  (b_working)
  );

endmodule

`default_nettype wire

// ===== sv/ade_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "array_double_ended_queue_assert.svh"

module ade_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic signed [ade_pkg::PORT_W-1:0] pop_value,
  input wire logic [1:0]                        status
);

  `ADE_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `ADE_ASSERT_IMP(a_done_busy, done, busy, "result outside a busy window")
  `ADE_ASSERT_NXT(a_done_single, done, !done, "result strobe longer than one cycle")
  `ADE_ASSERT_IMP(a_fail_value, done && (status != ade_pkg::ST_OK), pop_value == '1,
    "failed operation returned data")
  `ADE_ASSERT_IMP(a_busy_end, $fell(busy), $past(done), "busy dropped without a result")

endmodule

bind array_double_ended_queue ade_checker u_ade_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .pop_value(pop_value),
  .status   (status)
);

`default_nettype wire
